[rtl/core/first_fit_segment_allocator_defines.svh]
// assertion macros for the first-fit segment allocator
// used by the controller and datapath files, no other dependencies
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFSA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ffsa_pkg.sv]
// shared types and constants of the first-fit segment allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

   localparam int REQ_BYTES_W = 17;
   localparam int SEG_IDX_W   = 6;
   localparam int ADDR_W      = 16;
   localparam int RES_IDX_W   = 6;
   localparam int HEAP_W      = 17;

   localparam logic [HEAP_W-1:0] DEFAULT_HEAP = 17'd65536;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NO_SPACE     = 3'd1,
      ST_FRAGMENTED   = 3'd2,
      ST_BAD_INDEX    = 3'd3,
      ST_ALREADY_FREE = 3'd4,
      ST_TABLE_FULL   = 3'd5
   } status_type;

   typedef struct packed {
      logic                   kind;
      logic [REQ_BYTES_W-1:0] request_bytes;
      logic [SEG_IDX_W-1:0]   segment_index;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [ADDR_W-1:0]      address;
      logic [RES_IDX_W-1:0]   result_index;
   } rsp_type;

   typedef struct packed {
      logic [HEAP_W-1:0] heap_size;
   } csr_type;

   typedef enum logic [2:0] {
      RD_IDX  = 3'd0,
      RD_PREV = 3'd1,
      RD_NEXT = 3'd2,
      RD_INS  = 3'd3,
      RD_ERS  = 3'd4
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE     = 3'd0,
      WR_INIT     = 3'd1,
      WR_MARK     = 3'd2,
      WR_SPLIT_LO = 3'd3,
      WR_SPLIT_HI = 3'd4,
      WR_SHIFT_UP = 3'd5,
      WR_MERGE    = 3'd6,
      WR_SHIFT_DN = 3'd7
   } wr_sel_type;

   typedef struct packed {
      logic       init_tbl;
      logic       load_heap;
      logic       load_req;
      logic       idx_inc;
      logic       save_cur;
      logic       save_prev;
      logic       clr_prev;
      logic       save_next;
      logic       clr_next;
      logic       k_from_cnt;
      logic       k_dec;
      logic       k_inc;
      logic       alloc_commit;
      logic       split_commit;
      logic       merge_commit;
      logic       erase_commit;
      logic       res_set;
      status_type res_status;
      logic       res_alloc;
      logic       rsp_load;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
   } cmd_type;

   typedef struct packed {
      logic kind_free;
      logic over_total;
      logic zero_req;
      logic bad_index;
      logic walk_end;
      logic rd_in_use;
      logic fit_exact;
      logic fit_larger;
      logic table_full;
      logic has_prev;
      logic has_next;
      logic ins_more;
      logic ers_more;
      logic merge_any;
   } sts_type;

endpackage

`default_nettype wire

[rtl/core/ffsa_chan_if.sv]
// valid/ready channel carrying one payload beat
// payload type is set by the instantiating level, no other dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ffsa_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/ffsa_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ffsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/ffsa_ctrl.sv]
// controller state machine of the segment allocator
// depends on ffsa_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_segment_allocator_defines.svh"

module ffsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   input  ffsa_pkg::sts_type sts,
   output ffsa_pkg::cmd_type cmd
);
   import ffsa_pkg::*;

   typedef enum logic [15:0] {
      S_INIT     = 16'h0001,
      S_IDLE     = 16'h0002,
      S_CHECK    = 16'h0004,
      S_WALK_RD  = 16'h0008,
      S_WALK_CMP = 16'h0010,
      S_INS_RD   = 16'h0020,
      S_INS_WR   = 16'h0040,
      S_SPLIT_LO = 16'h0080,
      S_SPLIT_HI = 16'h0100,
      S_FCUR     = 16'h0200,
      S_FPREV    = 16'h0400,
      S_FNEXT    = 16'h0800,
      S_MERGE    = 16'h1000,
      S_ERS_RD   = 16'h2000,
      S_ERS_WR   = 16'h4000,
      S_DONE     = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.wr_sel   = WR_INIT;
            cmd.init_tbl = 1'b1;
            state_in     = S_IDLE;
         end
         S_IDLE: begin
            csr_ready = 1'b1;
            // a register write wins over a request in the same cycle
            req_ready = !csr_valid;
            if (csr_valid) begin
               cmd.load_heap = 1'b1;
               state_in      = S_INIT;
            end else if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.kind_free) begin
               if (sts.bad_index) begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_BAD_INDEX;
                  state_in       = S_DONE;
               end else begin
                  cmd.rd_sel = RD_IDX;
                  state_in   = S_FCUR;
               end
            end else if (sts.over_total) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NO_SPACE;
               state_in       = S_DONE;
            end else if (sts.zero_req) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_FRAGMENTED;
               state_in       = S_DONE;
            end else begin
               cmd.rd_sel = RD_IDX;
               state_in   = S_WALK_CMP;
            end
         end
         S_WALK_RD: begin
            if (sts.walk_end) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_FRAGMENTED;
               state_in       = S_DONE;
            end else begin
               cmd.rd_sel = RD_IDX;
               state_in   = S_WALK_CMP;
            end
         end
         S_WALK_CMP: begin
            cmd.save_cur = 1'b1;
            if (!sts.rd_in_use && sts.fit_exact) begin
               cmd.wr_sel       = WR_MARK;
               cmd.alloc_commit = 1'b1;
               cmd.res_alloc    = 1'b1;
               state_in         = S_DONE;
            end else if (!sts.rd_in_use && sts.fit_larger) begin
               if (sts.table_full) begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_TABLE_FULL;
                  state_in       = S_DONE;
               end else begin
                  cmd.res_alloc  = 1'b1;
                  cmd.k_from_cnt = 1'b1;
                  state_in       = S_INS_RD;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_WALK_RD;
            end
         end
         // open a hole at idx+1, moving entries up from the top
         S_INS_RD: begin
            if (sts.ins_more) begin
               cmd.rd_sel = RD_INS;
               state_in   = S_INS_WR;
            end else begin
               state_in = S_SPLIT_LO;
            end
         end
         S_INS_WR: begin
            cmd.wr_sel = WR_SHIFT_UP;
            cmd.k_dec  = 1'b1;
            state_in   = S_INS_RD;
         end
         S_SPLIT_LO: begin
            cmd.wr_sel       = WR_SPLIT_LO;
            cmd.alloc_commit = 1'b1;
            state_in         = S_SPLIT_HI;
         end
         S_SPLIT_HI: begin
            cmd.wr_sel       = WR_SPLIT_HI;
            cmd.split_commit = 1'b1;
            state_in         = S_DONE;
         end
         S_FCUR: begin
            cmd.save_cur = 1'b1;
            cmd.clr_prev = 1'b1;
            cmd.clr_next = 1'b1;
            if (!sts.rd_in_use) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_ALREADY_FREE;
               state_in       = S_DONE;
            end else if (sts.has_prev) begin
               cmd.rd_sel = RD_PREV;
               state_in   = S_FPREV;
            end else if (sts.has_next) begin
               cmd.rd_sel = RD_NEXT;
               state_in   = S_FNEXT;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_FPREV: begin
            cmd.save_prev = 1'b1;
            if (sts.has_next) begin
               cmd.rd_sel = RD_NEXT;
               state_in   = S_FNEXT;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_FNEXT: begin
            cmd.save_next = 1'b1;
            state_in      = S_MERGE;
         end
         S_MERGE: begin
            cmd.wr_sel       = WR_MERGE;
            cmd.merge_commit = 1'b1;
            state_in         = sts.merge_any ? S_ERS_RD : S_DONE;
         end
         // close the gap left by merged neighbors
         S_ERS_RD: begin
            if (sts.ers_more) begin
               cmd.rd_sel = RD_ERS;
               state_in   = S_ERS_WR;
            end else begin
               cmd.erase_commit = 1'b1;
               state_in         = S_DONE;
            end
         end
         S_ERS_WR: begin
            cmd.wr_sel = WR_SHIFT_DN;
            cmd.k_inc  = 1'b1;
            state_in   = S_ERS_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FFSA_ASSERT_NEXT(a_req_starts_check, clock, reset, req_valid && req_ready, state_ff == S_CHECK, "accepted request did not start a check")
   `FFSA_ASSERT_NEXT(a_csr_reinits, clock, reset, csr_valid && csr_ready, state_ff == S_INIT, "heap write did not reinitialize the table")
   `FFSA_ASSERT_NOW(a_no_rsp_overwrite, clock, reset, cmd.rsp_load, !rsp_valid_ff || rsp_ready, "pending result overwritten")

endmodule

`default_nettype wire

[rtl/core/ffsa_dpath.sv]
// datapath of the segment allocator: segment table ram, counters, merge and split math
// depends on ffsa_pkg, ffsa_ram and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_segment_allocator_defines.svh"

module ffsa_dpath #(
   parameter int MAX_SEGMENTS = 64,
   parameter int ADDR_BITS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  ffsa_pkg::cmd_type cmd,
   output ffsa_pkg::sts_type sts,
   input  ffsa_pkg::req_type req_payload,
   input  ffsa_pkg::csr_type csr_payload,
   output ffsa_pkg::rsp_type rsp_payload
);
   import ffsa_pkg::*;

   localparam int IW   = $clog2(MAX_SEGMENTS);
   localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
   localparam int LW   = ADDR_BITS + 1;
   localparam int EW   = ADDR_BITS + LW + 1;
   localparam int FW   = (LW > REQ_BYTES_W) ? LW : REQ_BYTES_W;
   localparam int SW   = FW + 1;
   localparam int XW   = (CNTW > SEG_IDX_W) ? CNTW : SEG_IDX_W;

   localparam logic [LW-1:0] HEAP_LIMIT = {1'b1, {ADDR_BITS{1'b0}}};
   localparam logic [LW-1:0] HEAP_RST   =
      (SW'(DEFAULT_HEAP) > SW'(HEAP_LIMIT)) ? HEAP_LIMIT : LW'(DEFAULT_HEAP);

   logic [LW-1:0]        heap_ff, used_ff;
   logic [CNTW-1:0]      cnt_ff, idx_ff, k_ff;
   req_type              req_ff;
   logic [ADDR_BITS-1:0] cur_start_ff, prev_start_ff;
   logic [LW-1:0]        cur_len_ff, prev_len_ff, next_len_ff;
   logic                 prev_free_ff, next_free_ff;
   rsp_type              res_ff, rsp_ff;

   logic                 ram_wr_en;
   logic [IW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [EW-1:0]        ram_wr_data, ram_rd_data;
   logic [ADDR_BITS-1:0] rd_start, mstart;
   logic [LW-1:0]        rd_len, bytes_l, mlen, heap_clamped;
   logic                 rd_use;
   logic [CNTW-1:0]      idx_p1, idx_m1, k_m1, base;
   logic [CNTW:0]        k_pd;
   logic [1:0]           merge_d;

   ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // entry layout: start, length, in-use
   assign rd_start = ram_rd_data[EW-1 -: ADDR_BITS];
   assign rd_len   = ram_rd_data[LW:1];
   assign rd_use   = ram_rd_data[0];

   assign bytes_l = LW'(req_ff.request_bytes);
   assign idx_p1  = idx_ff + 1'b1;
   assign idx_m1  = idx_ff - 1'b1;
   assign k_m1    = k_ff - 1'b1;
   assign merge_d = {1'b0, prev_free_ff} + {1'b0, next_free_ff};
   assign k_pd    = {1'b0, k_ff} + (CNTW+1)'(merge_d);
   assign base    = prev_free_ff ? idx_m1 : idx_ff;
   assign mstart  = prev_free_ff ? prev_start_ff : cur_start_ff;
   assign mlen    = (prev_free_ff ? prev_len_ff : '0) + cur_len_ff +
                    (next_free_ff ? next_len_ff : '0);

   assign heap_clamped =
      (csr_payload.heap_size == '0) ? LW'(1) :
      (SW'(csr_payload.heap_size) > SW'(HEAP_LIMIT)) ? HEAP_LIMIT :
      LW'(csr_payload.heap_size);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX:  ram_rd_addr = idx_ff[IW-1:0];
         RD_PREV: ram_rd_addr = idx_m1[IW-1:0];
         RD_NEXT: ram_rd_addr = idx_p1[IW-1:0];
         RD_INS:  ram_rd_addr = k_m1[IW-1:0];
         RD_ERS:  ram_rd_addr = k_pd[IW-1:0];
         default: ram_rd_addr = idx_ff[IW-1:0];
      endcase
   end

   always_comb begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = idx_ff[IW-1:0];
      ram_wr_data = ram_rd_data;
      unique case (cmd.wr_sel)
         WR_NONE: begin
            ram_wr_en = 1'b0;
         end
         WR_INIT: begin
            ram_wr_addr = '0;
            ram_wr_data = {{ADDR_BITS{1'b0}}, heap_ff, 1'b0};
         end
         WR_MARK: begin
            ram_wr_data = {rd_start, rd_len, 1'b1};
         end
         WR_SPLIT_LO: begin
            ram_wr_data = {cur_start_ff, bytes_l, 1'b1};
         end
         WR_SPLIT_HI: begin
            ram_wr_addr = idx_p1[IW-1:0];
            ram_wr_data = {ADDR_BITS'(LW'(cur_start_ff) + bytes_l),
                           cur_len_ff - bytes_l, 1'b0};
         end
         WR_SHIFT_UP, WR_SHIFT_DN: begin
            ram_wr_addr = k_ff[IW-1:0];
         end
         WR_MERGE: begin
            ram_wr_addr = base[IW-1:0];
            ram_wr_data = {mstart, mlen, 1'b0};
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      sts.kind_free  = req_ff.kind == KIND_FREE;
      sts.over_total = (SW'(used_ff) + SW'(req_ff.request_bytes)) > SW'(heap_ff);
      sts.zero_req   = req_ff.request_bytes == '0;
      sts.bad_index  = XW'(req_ff.segment_index) >= XW'(cnt_ff);
      sts.walk_end   = idx_ff >= cnt_ff;
      sts.rd_in_use  = rd_use;
      sts.fit_exact  = FW'(rd_len) == FW'(req_ff.request_bytes);
      sts.fit_larger = FW'(rd_len) > FW'(req_ff.request_bytes);
      sts.table_full = cnt_ff >= CNTW'(MAX_SEGMENTS);
      sts.has_prev   = idx_ff != '0;
      sts.has_next   = idx_p1 < cnt_ff;
      sts.ins_more   = k_ff > idx_p1;
      sts.ers_more   = k_pd < {1'b0, cnt_ff};
      sts.merge_any  = prev_free_ff | next_free_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff <= HEAP_RST;
         used_ff <= '0;
         cnt_ff  <= CNTW'(1);
      end else begin
         if (cmd.load_heap) begin
            heap_ff <= heap_clamped;
            used_ff <= '0;
            cnt_ff  <= CNTW'(1);
         end
         if (cmd.init_tbl) begin
            used_ff <= '0;
            cnt_ff  <= CNTW'(1);
         end
         if (cmd.alloc_commit) begin
            used_ff <= used_ff + bytes_l;
         end
         if (cmd.merge_commit) begin
            used_ff <= (used_ff >= cur_len_ff) ? used_ff - cur_len_ff : '0;
         end
         if (cmd.split_commit) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.erase_commit) begin
            cnt_ff <= cnt_ff - CNTW'(merge_d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
         idx_ff <= (req_payload.kind == KIND_FREE) ? CNTW'(req_payload.segment_index) : '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_p1;
      end
      if (cmd.save_cur) begin
         cur_start_ff <= rd_start;
         cur_len_ff   <= rd_len;
      end
      if (cmd.save_prev) begin
         prev_start_ff <= rd_start;
         prev_len_ff   <= rd_len;
         prev_free_ff  <= !rd_use;
      end else if (cmd.clr_prev) begin
         prev_free_ff <= 1'b0;
      end
      if (cmd.save_next) begin
         next_len_ff  <= rd_len;
         next_free_ff <= !rd_use;
      end else if (cmd.clr_next) begin
         next_free_ff <= 1'b0;
      end
      if (cmd.k_from_cnt) begin
         k_ff <= cnt_ff;
      end else if (cmd.k_dec) begin
         k_ff <= k_m1;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + 1'b1;
      end else if (cmd.merge_commit) begin
         k_ff <= base + 1'b1;
      end
      if (cmd.res_set) begin
         res_ff.status       <= cmd.res_status;
         res_ff.address      <= '0;
         res_ff.result_index <= '0;
      end else if (cmd.res_alloc) begin
         res_ff.status       <= ST_OK;
         res_ff.address      <= ADDR_W'(rd_start);
         res_ff.result_index <= RES_IDX_W'(idx_ff);
      end else if (cmd.merge_commit) begin
         res_ff.status       <= ST_OK;
         res_ff.address      <= '0;
         res_ff.result_index <= RES_IDX_W'(base);
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   `FFSA_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1, cnt_ff != '0 && cnt_ff <= CNTW'(MAX_SEGMENTS), "segment count out of range")
   `FFSA_ASSERT_NOW(a_used_le_heap, clock, reset, 1'b1, used_ff <= heap_ff, "used bytes exceed heap size")

endmodule

`default_nettype wire

[rtl/core/first_fit_segment_allocator.sv]
// top level of the first-fit segment allocator with coalescing
// depends on ffsa_pkg, ffsa_chan_if, ffsa_ctrl, ffsa_dpath (and ffsa_ram below it)
//
//   channel  direction  payload                                  beat when
//   req_if   in         kind, request_bytes, segment_index       valid && ready
//   rsp_if   out        status, address, result_index            valid && ready
//   csr_if   in         heap_size                                valid && ready
//
// allocate: check, compare first segment, read and compare each further one, last read on a miss
// a split moves seg_count - idx - 1 entries up over the one ram port, then writes both halves
// free: read the segment and its neighbours, a merge write, then move entries down on a merge
// done loads the result register, then idle takes the next request
// after reset or a heap_size write, the init state rewrites table entry zero; no clearing pass
// done waits while the previous result is still not taken
`timescale 1ns / 1ps
`default_nettype none

module first_fit_segment_allocator #(
   parameter int MAX_SEGMENTS = 64,
   parameter int ADDR_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   ffsa_chan_if.sink   req_if,
   ffsa_chan_if.source rsp_if,
   ffsa_chan_if.sink   csr_if
);
   import ffsa_pkg::*;

   cmd_type cmd;
   sts_type sts;
   req_type req_pl;
   csr_type csr_pl;
   rsp_type rsp_pl;

   assign req_pl         = req_if.payload;
   assign csr_pl         = csr_if.payload;
   assign rsp_if.payload = rsp_pl;

   ffsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .csr_valid (csr_if.valid),
      .csr_ready (csr_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffsa_dpath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_pl),
      .csr_payload (csr_pl),
      .rsp_payload (rsp_pl)
   );

endmodule

`default_nettype wire

[tb/first_fit_segment_allocator_test.sv]
// self-checking testbench of first_fit_segment_allocator: directed and random allocate/free
// traffic with a heap_size scoreboard; depends on ffsa_pkg, ffsa_chan_if and the rtl
`timescale 1ns / 1ps

module first_fit_segment_allocator_test;
   import ffsa_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 2000000;

   class heap_scoreboard;
      bit [15:0]  seg_start [TABLE_DEPTH];
      bit [16:0]  seg_len [TABLE_DEPTH];
      bit         seg_used [TABLE_DEPTH];
      int         seg_cnt;
      int         used_total;
      int         heap_bytes;
      int         errors;
      rsp_type    expected_rsp [$];

      function void clear_table();
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            seg_start[k] = 0;
            seg_len[k] = 0;
            seg_used[k] = 0;
         end
         seg_len[0] = 17'(heap_bytes);
         seg_cnt = 1;
         used_total = 0;
      endfunction

      function void set_heap(bit [16:0] value);
         heap_bytes = int'(value);
         if (heap_bytes < 1) heap_bytes = 1;
         if (heap_bytes > 65536) heap_bytes = 65536;
         clear_table();
      endfunction

      function void remove_entry(int pos);
         for (int k = pos; k + 1 < seg_cnt; k++) begin
            seg_start[k] = seg_start[k + 1];
            seg_len[k] = seg_len[k + 1];
            seg_used[k] = seg_used[k + 1];
         end
         seg_cnt--;
         seg_start[seg_cnt] = 0;
         seg_len[seg_cnt] = 0;
         seg_used[seg_cnt] = 0;
      endfunction

      function rsp_type allocate(int bytes);
         rsp_type r;
         r = '{status: ST_FRAGMENTED, address: '0, result_index: '0};
         if (used_total + bytes > heap_bytes) begin
            r.status = ST_NO_SPACE;
            return r;
         end
         if (bytes == 0) return r;
         for (int i = 0; i < seg_cnt; i++) begin
            if (seg_used[i]) continue;
            if (seg_len[i] == bytes) begin
               seg_used[i] = 1;
               used_total += bytes;
               r = '{status: ST_OK, address: seg_start[i], result_index: RES_IDX_W'(i)};
               return r;
            end
            if (seg_len[i] > bytes) begin
               if (seg_cnt >= TABLE_DEPTH) begin
                  r.status = ST_TABLE_FULL;
                  return r;
               end
               for (int k = seg_cnt; k > i; k--) begin
                  seg_start[k] = seg_start[k - 1];
                  seg_len[k] = seg_len[k - 1];
                  seg_used[k] = seg_used[k - 1];
               end
               seg_cnt++;
               seg_len[i] = 17'(bytes);
               seg_used[i] = 1;
               seg_start[i + 1] = 16'(int'(seg_start[i]) + bytes);
               seg_len[i + 1] = 17'(int'(seg_len[i + 1]) - bytes);
               seg_used[i + 1] = 0;
               used_total += bytes;
               r = '{status: ST_OK, address: seg_start[i], result_index: RES_IDX_W'(i)};
               return r;
            end
         end
         return r;
      endfunction

      function rsp_type release_segment(int i);
         rsp_type r;
         r = '{status: ST_OK, address: '0, result_index: '0};
         if (i >= seg_cnt) begin
            r.status = ST_BAD_INDEX;
            return r;
         end
         if (!seg_used[i]) begin
            r.status = ST_ALREADY_FREE;
            return r;
         end
         seg_used[i] = 0;
         used_total = (used_total >= seg_len[i]) ? used_total - int'(seg_len[i]) : 0;
         if (i > 0 && !seg_used[i - 1]) begin
            seg_len[i - 1] += seg_len[i];
            remove_entry(i);
            i--;
         end
         if (i + 1 < seg_cnt && !seg_used[i + 1]) begin
            seg_len[i] += seg_len[i + 1];
            remove_entry(i + 1);
         end
         r.result_index = RES_IDX_W'(i);
         return r;
      endfunction

      function void note_request(req_type q);
         rsp_type want;
         if (q.kind == KIND_ALLOC) want = allocate(int'(q.request_bytes));
         else want = release_segment(int'(q.segment_index));
         expected_rsp = {expected_rsp, want};
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response, actual %p", $time, got);
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.address !== want.address) begin
            $display("%0t: address expected %0d actual %0d", $time, want.address, got.address);
            errors++;
         end
         if (got.result_index !== want.result_index) begin
            $display("%0t: result_index expected %0d actual %0d", $time, want.result_index,
                     got.result_index);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   bursty = 1'b1;
   int   cycles = 0;
   int   stall_left = 0;
   heap_scoreboard sb = new();

   ffsa_chan_if #(.payload_type(req_type)) req_ch ();
   ffsa_chan_if #(.payload_type(rsp_type)) rsp_ch ();
   ffsa_chan_if #(.payload_type(csr_type)) csr_ch ();

   first_fit_segment_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("first_fit_segment_allocator_test NOT OK");
         $finish;
      end
   end

   // response side: check each beat, stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.payload);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (bursty && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(req_type q);
      if (bursty && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= q;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(q);
   endtask

   task automatic request_alloc(int bytes);
      req_type q;
      q.kind = KIND_ALLOC;
      q.request_bytes = REQ_BYTES_W'(bytes);
      q.segment_index = SEG_IDX_W'($urandom);
      send_request(q);
   endtask

   task automatic request_free(int idx);
      req_type q;
      q.kind = KIND_FREE;
      q.request_bytes = REQ_BYTES_W'($urandom);
      q.segment_index = SEG_IDX_W'(idx);
      send_request(q);
   endtask

   // drain outstanding responses, then write heap_size
   task automatic write_heap(bit [16:0] value);
      req_ch.valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.payload <= '{heap_size: value};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      sb.set_heap(value);
   endtask

   task automatic random_traffic(int count);
      int pick;
      int idx;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 4) begin
            idx = $urandom_range(0, 63);
            // mostly target a segment currently in use
            if ($urandom_range(0, 6) != 0) begin
               for (int t = 0; t < 8; t++) begin
                  pick = $urandom_range(0, sb.seg_cnt - 1);
                  if (sb.seg_used[pick]) begin
                     idx = pick;
                     break;
                  end
               end
            end
            request_free(idx);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) request_alloc(0);
            else if (pick < 8) request_alloc($urandom_range(0, 131071));
            else if (pick < 14) request_alloc(sb.heap_bytes - sb.used_total);
            else request_alloc($urandom_range(1, (sb.heap_bytes + 15) / 16));
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      sb.set_heap(DEFAULT_HEAP);
      @(posedge clock);

      // directed: zero request, whole heap, overflow, bad and double frees, merges
      request_alloc(0);
      request_alloc(65536);
      request_alloc(1);
      request_free(0);
      request_free(63);
      request_free(0);
      request_alloc(131071);
      request_alloc(100);
      request_alloc(200);
      request_alloc(300);
      request_free(1);
      request_free(0);
      request_free(1);
      request_free(0);
      request_alloc(65535);
      request_alloc(1);
      request_alloc(1);
      request_free(1);
      request_free(0);

      write_heap(17'd0);
      request_alloc(1);
      request_alloc(1);
      request_free(0);
      write_heap(17'd131071);
      random_traffic(110);
      write_heap(17'd100);
      random_traffic(150);
      write_heap(17'd1);
      random_traffic(40);
      write_heap(17'd4096);
      random_traffic(130);
      write_heap(17'd700);
      random_traffic(150);
      write_heap(17'd65536);
      random_traffic(110);
      bursty = 1'b0;
      random_traffic(90);
      req_ch.valid <= 1'b0;

      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("first_fit_segment_allocator_test OK");
      else
         $display("first_fit_segment_allocator_test NOT OK");
      $finish;
   end
endmodule

[first_fit_segment_allocator.f]
+incdir+rtl/core
rtl/core/ffsa_pkg.sv
rtl/core/ffsa_chan_if.sv
rtl/core/ffsa_ram.sv
rtl/core/ffsa_ctrl.sv
rtl/core/ffsa_dpath.sv
rtl/core/first_fit_segment_allocator.sv
tb/first_fit_segment_allocator_test.sv
